>>> design/salc_pkg.sv
// Shared constants for the set-associative LRU cache lookup unit.
package salc_pkg;

   localparam int CACHE_ENTRIES_DEF = 256;
   localparam int MAX_WAYS_DEF      = 4;
   localparam int ADDRESS_BITS_DEF  = 32;

   localparam int COUNT_BITS = 32;
   localparam int WAYS_BITS  = 2;

   localparam logic [WAYS_BITS-1:0]  WAYS_LOG2_RESET = 2'd2;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX       = {COUNT_BITS{1'b1}};

endpackage

>>> design/salc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module salc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/set_assoc_lru_cache_lookup_unit.sv
// Top level of the set-associative LRU cache lookup unit.
//
// The unit takes one address transaction per clock cycle unless the result
// side stalls and returns one result transaction for each through the stage
// and result registers. The cache entries are kept as rows of up to MAX_WAYS
// lanes in two RAMs (stored addresses and recency ranks); one set always
// lies in a single row, so each transaction reads its row at acceptance and
// writes the updated row back as it leaves the stage, forwarding the written
// row to a following transaction that maps to the same row. A per-row valid
// bit makes rows read as their reset contents, so reset and a write of the
// ways register take effect at once, with no clearing pass.
// CACHE_ENTRIES must be a power of two.
module set_assoc_lru_cache_lookup_unit #(
   parameter int CACHE_ENTRIES = salc_pkg::CACHE_ENTRIES_DEF,
   parameter int MAX_WAYS      = salc_pkg::MAX_WAYS_DEF,
   parameter int ADDRESS_BITS  = salc_pkg::ADDRESS_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ADDRESS_BITS-1:0]         req_address,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_hit,
   output logic [salc_pkg::COUNT_BITS-1:0] rsp_hit_total,
   output logic [salc_pkg::COUNT_BITS-1:0] rsp_miss_total,
   input  logic                            csr_wr_en,
   input  logic [salc_pkg::WAYS_BITS-1:0]  csr_wr_data
);

   import salc_pkg::*;

   localparam int LANES_LOG  = $clog2(MAX_WAYS + 1) - 1;
   localparam int LANES      = 1 << LANES_LOG;
   localparam int LANE_BITS  = (LANES_LOG > 0) ? LANES_LOG : 1;
   localparam int RANK_BITS  = (LANES_LOG > 0) ? LANES_LOG : 1;
   localparam int ENTRY_BITS = $clog2(CACHE_ENTRIES);
   localparam int ROWS       = CACHE_ENTRIES / LANES;
   localparam int ROW_BITS   = ENTRY_BITS - LANES_LOG;
   localparam int EXT_BITS   = (ENTRY_BITS > ADDRESS_BITS) ? ENTRY_BITS : ADDRESS_BITS;

   localparam logic [ENTRY_BITS-1:0] ENTRY_MASK = ENTRY_BITS'(CACHE_ENTRIES - 1);
   localparam logic [ENTRY_BITS-1:0] LANE_MASK  = ENTRY_BITS'(LANES - 1);

   logic [WAYS_BITS-1:0]    ways_ff;
   logic [WAYS_BITS-1:0]    ways_eff;
   logic [RANK_BITS-1:0]    way_mask;
   logic [LANE_BITS-1:0]    lane_mask;

   logic                    accept;
   logic                    s1_move;
   logic [EXT_BITS-1:0]     in_addr_ext;
   logic [ENTRY_BITS-1:0]   in_base;
   logic [ROW_BITS-1:0]     in_row;
   logic [LANE_BITS-1:0]    in_off;

   logic                    s1_valid_ff;
   logic [ADDRESS_BITS-1:0] s1_addr_ff;
   logic [ROW_BITS-1:0]     s1_row_ff;
   logic [LANE_BITS-1:0]    s1_off_ff;
   logic                    s1_avld_ff;
   logic                    s1_rvld_ff;
   logic                    fwd_ff;
   logic [LANES*ADDRESS_BITS-1:0] fwd_addr_ff;
   logic [LANES*RANK_BITS-1:0]    fwd_rank_ff;

   logic [ROWS-1:0]         avld_ff;
   logic [ROWS-1:0]         rvld_ff;

   logic [LANES*ADDRESS_BITS-1:0] ram_addr_rd;
   logic [LANES*RANK_BITS-1:0]    ram_rank_rd;
   logic [LANES*ADDRESS_BITS-1:0] new_addr_row;
   logic [LANES*RANK_BITS-1:0]    new_rank_row;

   logic [ADDRESS_BITS-1:0] cur_addr [LANES];
   logic [RANK_BITS-1:0]    cur_rank [LANES];
   logic [LANES-1:0]        in_set;
   logic [LANES-1:0]        match;
   logic                    hit;
   logic [LANE_BITS-1:0]    hit_lane;
   logic                    vic_found;
   logic [LANE_BITS-1:0]    vic_lane;
   logic                    touch_en;
   logic [LANE_BITS-1:0]    touch_lane;
   logic [RANK_BITS-1:0]    touch_rank;

   logic [COUNT_BITS-1:0]   hit_cnt_ff;
   logic [COUNT_BITS-1:0]   hit_cnt_in;
   logic [COUNT_BITS-1:0]   miss_cnt_ff;
   logic [COUNT_BITS-1:0]   miss_cnt_in;

   logic                    rsp_valid_ff;
   logic                    rsp_hit_ff;
   logic [COUNT_BITS-1:0]   rsp_hit_total_ff;
   logic [COUNT_BITS-1:0]   rsp_miss_total_ff;

   // Associativity above the lane count saturates to the lane count.
   assign ways_eff  = (int'(ways_ff) > LANES_LOG) ? WAYS_BITS'(LANES_LOG) : ways_ff;
   assign way_mask  = ~(~RANK_BITS'(0) << ways_eff);
   assign lane_mask = ~(~LANE_BITS'(0) << ways_eff);

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;

   assign in_addr_ext = EXT_BITS'(req_address);
   assign in_base     = ((in_addr_ext[ENTRY_BITS-1:0] & (ENTRY_MASK >> ways_eff)) << ways_eff);
   assign in_row      = in_base[ENTRY_BITS-1 -: ROW_BITS];
   assign in_off      = LANE_BITS'(in_base & LANE_MASK);

   salc_ram #(
      .WIDTH (LANES * ADDRESS_BITS),
      .DEPTH (ROWS)
   ) u_addr_ram (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_row_ff),
      .wr_data (new_addr_row),
      .rd_en   (accept),
      .rd_addr (in_row),
      .rd_data (ram_addr_rd)
   );

   salc_ram #(
      .WIDTH (LANES * RANK_BITS),
      .DEPTH (ROWS)
   ) u_rank_ram (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_row_ff),
      .wr_data (new_rank_row),
      .rd_en   (accept),
      .rd_addr (in_row),
      .rd_data (ram_rank_rd)
   );

   always_comb begin
      for (int b = 0; b < LANES; b++) begin
         if (fwd_ff) begin
            cur_addr[b] = fwd_addr_ff[b*ADDRESS_BITS +: ADDRESS_BITS];
            cur_rank[b] = fwd_rank_ff[b*RANK_BITS +: RANK_BITS];
         end else begin
            cur_addr[b] = s1_avld_ff ? ram_addr_rd[b*ADDRESS_BITS +: ADDRESS_BITS]
                                     : '0;
            cur_rank[b] = s1_rvld_ff ? ram_rank_rd[b*RANK_BITS +: RANK_BITS]
                                     : (RANK_BITS'(b) & way_mask);
         end
         in_set[b] = ((LANE_BITS'(b) & ~lane_mask) == s1_off_ff);
         match[b]  = in_set[b] && (cur_addr[b] == s1_addr_ff);
      end
   end

   always_comb begin
      hit       = 1'b0;
      hit_lane  = '0;
      vic_found = 1'b0;
      vic_lane  = '0;
      for (int b = 0; b < LANES; b++) begin
         if (match[b] && !hit) begin
            hit      = 1'b1;
            hit_lane = LANE_BITS'(b);
         end
         if (in_set[b] && (cur_rank[b] == '0) && !vic_found) begin
            vic_found = 1'b1;
            vic_lane  = LANE_BITS'(b);
         end
      end
   end

   assign touch_en   = hit || vic_found;
   assign touch_lane = hit ? hit_lane : vic_lane;
   assign touch_rank = cur_rank[touch_lane];

   always_comb begin
      for (int b = 0; b < LANES; b++) begin
         if (touch_en && in_set[b]) begin
            if (LANE_BITS'(b) == touch_lane) begin
               new_rank_row[b*RANK_BITS +: RANK_BITS] = way_mask;
            end else if (cur_rank[b] > touch_rank) begin
               new_rank_row[b*RANK_BITS +: RANK_BITS] = cur_rank[b] - RANK_BITS'(1);
            end else begin
               new_rank_row[b*RANK_BITS +: RANK_BITS] = cur_rank[b];
            end
         end else begin
            new_rank_row[b*RANK_BITS +: RANK_BITS] = cur_rank[b];
         end
         if (!hit && vic_found && (LANE_BITS'(b) == vic_lane)) begin
            new_addr_row[b*ADDRESS_BITS +: ADDRESS_BITS] = s1_addr_ff;
         end else begin
            new_addr_row[b*ADDRESS_BITS +: ADDRESS_BITS] = cur_addr[b];
         end
      end
   end

   assign hit_cnt_in  = (hit && (hit_cnt_ff != COUNT_MAX)) ? hit_cnt_ff + 1'b1 : hit_cnt_ff;
   assign miss_cnt_in = (!hit && (miss_cnt_ff != COUNT_MAX)) ? miss_cnt_ff + 1'b1
                                                             : miss_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ways_ff      <= WAYS_LOG2_RESET;
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         avld_ff      <= '0;
         rvld_ff      <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
            fwd_ff      <= s1_move && (s1_row_ff == in_row);
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
            fwd_ff      <= 1'b0;
         end
         if (s1_move) begin
            avld_ff[s1_row_ff] <= 1'b1;
            rvld_ff[s1_row_ff] <= 1'b1;
            hit_cnt_ff         <= hit_cnt_in;
            miss_cnt_ff        <= miss_cnt_in;
            rsp_valid_ff       <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         // A new geometry puts every rank back to its way index.
         if (csr_wr_en) begin
            ways_ff <= csr_wr_data;
            rvld_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff  <= req_address;
         s1_row_ff   <= in_row;
         s1_off_ff   <= in_off;
         s1_avld_ff  <= avld_ff[in_row];
         s1_rvld_ff  <= rvld_ff[in_row];
         fwd_addr_ff <= new_addr_row;
         fwd_rank_ff <= new_rank_row;
      end
      if (s1_move) begin
         rsp_hit_ff        <= hit;
         rsp_hit_total_ff  <= hit_cnt_in;
         rsp_miss_total_ff <= miss_cnt_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_hit_total  = rsp_hit_total_ff;
   assign rsp_miss_total = rsp_miss_total_ff;

   // Every set always holds a least recently used way.
   a_victim_exists : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (hit || vic_found))
      else $error("no way of rank zero in the selected set");

   a_fwd_needs_item : assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> s1_valid_ff)
      else $error("row forwarding active without a transaction in flight");

   a_one_count_step : assert property (@(posedge clock) disable iff (reset)
      (s1_move && (hit_cnt_ff != COUNT_MAX) && (miss_cnt_ff != COUNT_MAX)) |=>
      (COUNT_BITS'((hit_cnt_ff - $past(hit_cnt_ff)) + (miss_cnt_ff - $past(miss_cnt_ff)))
       == COUNT_BITS'(1)))
      else $error("totals did not advance by exactly one");

   a_rsp_from_stage : assert property (@(posedge clock) disable iff (reset)
      s1_move |=> (rsp_valid_ff && (rsp_hit_total_ff == hit_cnt_ff)
                   && (rsp_miss_total_ff == miss_cnt_ff)))
      else $error("result totals differ from the counters");

endmodule
